>>> design/ens3_pkg.sv
// shared types, constants and helper functions for the 3x3 edge-normalized smoothing filter
package ens3_pkg;

   // image geometry limits
   localparam int MAX_COLS = 1024;
   localparam int MAX_ROWS = 1024;
   localparam int CNT_W    = 11;
   localparam int COL_AW   = $clog2(MAX_COLS);

   // field widths
   localparam int PIX_W = 16;
   localparam int CHK_W = 36;
   localparam int WIN_W = 3 * PIX_W;

   // job queue between front and back
   localparam int Q_DEPTH = 4;
   localparam int Q_AW    = $clog2(Q_DEPTH);

   // register file
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_ROWS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_COLS = 2'd1;

   // request kinds
   localparam logic REQ_PIXEL = 1'b0;
   localparam logic REQ_DRAIN = 1'b1;

   // reciprocal scaling for the weight divide
   localparam int RECIP_SHIFT = 24;
   localparam int RECIP_W     = 23;

   typedef struct packed {
      logic                    req_type;
      logic signed [PIX_W-1:0] pixel_value;
   } req_item_type;

   typedef struct packed {
      logic signed [PIX_W-1:0] filtered_value;
      logic signed [CHK_W-1:0] running_check;
      logic                    last_of_image;
   } rsp_item_type;

   // one filter job: three window columns packed top|mid|bottom plus edge flags
   typedef struct packed {
      logic [WIN_W-1:0] col_left;
      logic [WIN_W-1:0] col_mid;
      logic [WIN_W-1:0] col_right;
      logic             top_on;
      logic             bot_on;
      logic             left_on;
      logic             right_on;
      logic             last;
   } job_type;

   // clamp a size register into 1..lim
   function automatic logic [CNT_W-1:0] eff_size(input logic [CNT_W-1:0] v,
                                                 input logic [CNT_W-1:0] lim);
      logic [CNT_W-1:0] r;
      if (v == '0) begin
         r = CNT_W'(1);
      end else if (v > lim) begin
         r = lim;
      end else begin
         r = v;
      end
      return r;
   endfunction

   // ceil(2^24 / weight) for the weights a clipped 1-2-1 kernel can have
   function automatic logic [RECIP_W-1:0] recip(input logic [2:0] rf, input logic [2:0] cf);
      logic [5:0]         w;
      logic [RECIP_W-1:0] m;
      w = 6'(rf * cf);
      case (w)
         6'd4:    m = 23'd4194304;
         6'd6:    m = 23'd2796203;
         6'd8:    m = 23'd2097152;
         6'd9:    m = 23'd1864136;
         6'd12:   m = 23'd1398102;
         6'd16:   m = 23'd1048576;
         default: m = 23'd1048576;
      endcase
      return m;
   endfunction

endpackage

>>> design/ens3_queue.sv
// short job queue between the front and the back of the filter
module ens3_queue import ens3_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  job_type       push_data,
   input  logic          pop,
   output job_type       pop_data,
   output logic          not_empty,
   output logic [Q_AW:0] count
);

   job_type         slot_ff [Q_DEPTH];
   logic [Q_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [Q_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [Q_AW:0]   count_ff, count_in;

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + Q_AW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + Q_AW'(1) : rd_ptr_ff;
      count_in  = count_ff + (Q_AW+1)'(push) - (Q_AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data  = slot_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign count     = count_ff;

endmodule

>>> design/ens3_front.sv
// front end: accepts requests, keeps line stores and window, issues filter jobs
module ens3_front import ens3_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_item_type         req_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CNT_W-1:0]     csr_wdata,
   input  logic [Q_AW:0]        q_count,
   output logic                 push,
   output job_type              push_data,
   output logic                 img_clear
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PIX,
      ST_PIX2,
      ST_DRN_A,
      ST_DRN_B
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] rows_ff, rows_in;
   logic [CNT_W-1:0] cols_ff, cols_in;
   logic [CNT_W-1:0] row_ff, row_in;
   logic [CNT_W-1:0] col_ff, col_in;
   logic [CNT_W-1:0] drain_ff, drain_in;
   logic [PIX_W-1:0] pix_ff, pix_in;
   logic             r1_ff, r1_in;
   logic             r2_ff, r2_in;
   logic             c1_ff, c1_in;
   logic             c2_ff, c2_in;
   logic             clast_ff, clast_in;
   logic [WIN_W-1:0] win_ff [3];
   logic [WIN_W-1:0] win_in [3];

   logic [PIX_W-1:0] upper_mem [MAX_COLS];
   logic [PIX_W-1:0] lower_mem [MAX_COLS];
   logic [PIX_W-1:0] upper_rd_ff;
   logic [PIX_W-1:0] lower_rd_ff;
   logic [COL_AW-1:0] rd_addr;
   logic [COL_AW-1:0] wr_addr;
   logic              wr_en;

   logic [CNT_W-1:0] rows_eff;
   logic [CNT_W-1:0] cols_eff;
   logic [CNT_W-1:0] col_next;
   logic [CNT_W-1:0] drain_next;
   logic             accept;
   logic             csr_write;
   logic             px_ok;
   logic             dr_ok;
   logic             need1;
   logic             need2;
   logic             drain_last;
   logic [WIN_W-1:0] shift_col;
   job_type          job_one;
   job_type          job_two_new;
   job_type          job_two_old;
   job_type          job_drain;

   assign rows_eff = eff_size(rows_ff, CNT_W'(MAX_ROWS));
   assign cols_eff = eff_size(cols_ff, CNT_W'(MAX_COLS));

   // handshakes
   assign req_stall = !((state_ff == ST_IDLE) && (q_count <= (Q_AW+1)'(Q_DEPTH - 2)));
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready &&
                      ((csr_index == CSR_IMAGE_ROWS) || (csr_index == CSR_IMAGE_COLS));
   assign img_clear = csr_write;

   // position checks
   assign px_ok      = (row_ff < rows_eff) && (col_ff < cols_eff);
   assign dr_ok      = (row_ff >= rows_eff) && (drain_ff < cols_eff);
   assign col_next   = col_ff + CNT_W'(1);
   assign drain_next = drain_ff + CNT_W'(1);
   assign drain_last = (drain_ff == cols_eff - CNT_W'(1));
   assign need1      = r1_ff && c1_ff;
   assign need2      = r1_ff && clast_ff;

   // line store read address
   always_comb begin
      case (state_ff)
         ST_DRN_A: rd_addr = COL_AW'(1);
         default: begin
            if (req_data.req_type == REQ_DRAIN) begin
               rd_addr = (drain_ff == '0) ? '0 : COL_AW'(drain_next);
            end else begin
               rd_addr = col_ff[COL_AW-1:0];
            end
         end
      endcase
   end

   // line store update on a pixel: upper takes old lower, lower takes the pixel
   assign wr_en   = (state_ff == ST_PIX);
   assign wr_addr = col_ff[COL_AW-1:0];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         upper_mem[wr_addr] <= lower_rd_ff;
         lower_mem[wr_addr] <= pix_ff;
      end
      upper_rd_ff <= upper_mem[rd_addr];
      lower_rd_ff <= lower_mem[rd_addr];
   end

   // window shift and job building
   always_comb begin
      shift_col = {upper_rd_ff, lower_rd_ff, (state_ff == ST_PIX) ? pix_ff : PIX_W'(0)};
      win_in[0] = win_ff[1];
      win_in[1] = win_ff[2];
      win_in[2] = shift_col;

      job_one.col_left  = win_in[0];
      job_one.col_mid   = win_in[1];
      job_one.col_right = win_in[2];
      job_one.top_on    = r2_ff;
      job_one.bot_on    = 1'b1;
      job_one.left_on   = c2_ff;
      job_one.right_on  = 1'b1;
      job_one.last      = 1'b0;

      job_two_new.col_left  = win_in[1];
      job_two_new.col_mid   = win_in[2];
      job_two_new.col_right = win_in[2];
      job_two_new.top_on    = r2_ff;
      job_two_new.bot_on    = 1'b1;
      job_two_new.left_on   = c1_ff;
      job_two_new.right_on  = 1'b0;
      job_two_new.last      = 1'b0;

      job_two_old           = job_two_new;
      job_two_old.col_left  = win_ff[1];
      job_two_old.col_mid   = win_ff[2];
      job_two_old.col_right = win_ff[2];

      job_drain.col_left  = win_in[0];
      job_drain.col_mid   = win_in[1];
      job_drain.col_right = win_in[2];
      job_drain.top_on    = (rows_eff >= CNT_W'(2));
      job_drain.bot_on    = 1'b0;
      job_drain.left_on   = (drain_ff != '0);
      job_drain.right_on  = (drain_next < cols_eff);
      job_drain.last      = drain_last;
   end

   // sequencer next state
   always_comb begin
      state_in  = state_ff;
      rows_in   = rows_ff;
      cols_in   = cols_ff;
      row_in    = row_ff;
      col_in    = col_ff;
      drain_in  = drain_ff;
      pix_in    = pix_ff;
      r1_in     = r1_ff;
      r2_in     = r2_ff;
      c1_in     = c1_ff;
      c2_in     = c2_ff;
      clast_in  = clast_ff;
      push      = 1'b0;
      push_data = job_one;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_data.req_type == REQ_DRAIN) begin
                  if (dr_ok) begin
                     state_in = (drain_ff == '0) ? ST_DRN_A : ST_DRN_B;
                  end
               end else if (px_ok) begin
                  pix_in   = req_data.pixel_value;
                  r1_in    = (row_ff >= CNT_W'(1));
                  r2_in    = (row_ff >= CNT_W'(2));
                  c1_in    = (col_ff >= CNT_W'(1));
                  c2_in    = (col_ff >= CNT_W'(2));
                  clast_in = (col_ff == cols_eff - CNT_W'(1));
                  state_in = ST_PIX;
               end
            end
         end
         ST_PIX: begin
            if (col_next >= cols_eff) begin
               col_in = '0;
               row_in = row_ff + CNT_W'(1);
            end else begin
               col_in = col_next;
            end
            if (need1) begin
               push      = 1'b1;
               push_data = job_one;
               state_in  = need2 ? ST_PIX2 : ST_IDLE;
            end else begin
               push      = need2;
               push_data = job_two_new;
               state_in  = ST_IDLE;
            end
         end
         ST_PIX2: begin
            push      = 1'b1;
            push_data = job_two_old;
            state_in  = ST_IDLE;
         end
         ST_DRN_A: begin
            state_in = ST_DRN_B;
         end
         ST_DRN_B: begin
            push      = 1'b1;
            push_data = job_drain;
            state_in  = ST_IDLE;
            if (drain_last) begin
               row_in   = '0;
               col_in   = '0;
               drain_in = '0;
            end else begin
               drain_in = drain_next;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // register writes abort the image
      if (csr_write) begin
         if (csr_index == CSR_IMAGE_ROWS) begin
            rows_in = csr_wdata;
         end else begin
            cols_in = csr_wdata;
         end
         row_in   = '0;
         col_in   = '0;
         drain_in = '0;
      end
   end

   // state and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rows_ff  <= CNT_W'(1);
         cols_ff  <= CNT_W'(1);
         row_ff   <= '0;
         col_ff   <= '0;
         drain_ff <= '0;
      end else begin
         state_ff <= state_in;
         rows_ff  <= rows_in;
         cols_ff  <= cols_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         drain_ff <= drain_in;
      end
      pix_ff   <= pix_in;
      r1_ff    <= r1_in;
      r2_ff    <= r2_in;
      c1_ff    <= c1_in;
      c2_ff    <= c2_in;
      clast_ff <= clast_in;
      if ((state_ff == ST_PIX) || (state_ff == ST_DRN_A) || (state_ff == ST_DRN_B)) begin
         for (int i = 0; i < 3; i++) begin
            win_ff[i] <= win_in[i];
         end
      end
   end

endmodule

>>> design/ens3_back.sv
// back end: weighted sum, divide by present weight, running check, result register
module ens3_back import ens3_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         q_not_empty,
   input  job_type      q_data,
   output logic         pop,
   input  logic         img_clear,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_data
);

   localparam int RS_W   = 19;
   localparam int TOT_W  = 21;
   localparam int MAG_W  = 20;
   localparam int PROD_W = MAG_W + RECIP_W;
   localparam int Q_W    = 17;

   logic                    s1_valid_ff;
   logic signed [RS_W-1:0]  s1_rs_ff [3];
   logic                    s1_top_ff;
   logic                    s1_bot_ff;
   logic [2:0]              s1_cf_ff;
   logic                    s1_last_ff;

   logic                    s2_valid_ff;
   logic                    s2_neg_ff;
   logic [MAG_W-1:0]        s2_mag_ff;
   logic [RECIP_W-1:0]      s2_recip_ff;
   logic                    s2_last_ff;

   logic                    s3_valid_ff;
   logic                    s3_neg_ff;
   logic [PROD_W-1:0]       s3_prod_ff;
   logic                    s3_last_ff;

   logic                    rsp_valid_ff;
   rsp_item_type            rsp_data_ff;
   logic signed [CHK_W-1:0] acc_ff, acc_in;

   logic                    en;
   logic signed [RS_W-1:0]  rs_in [3];
   logic signed [TOT_W-1:0] total;
   logic [2:0]              rf;
   logic [Q_W-1:0]          qmag;
   logic signed [Q_W:0]     qval;
   logic signed [CHK_W-1:0] check_sum;

   // one row of the window with 1-2-1 column weights
   function automatic logic signed [RS_W-1:0] row_sum(input logic [PIX_W-1:0] a,
                                                      input logic [PIX_W-1:0] b,
                                                      input logic [PIX_W-1:0] c,
                                                      input logic lo,
                                                      input logic ro);
      logic signed [RS_W-1:0] sa;
      logic signed [RS_W-1:0] sb;
      logic signed [RS_W-1:0] sc;
      sa = lo ? RS_W'($signed(a)) : '0;
      sb = RS_W'($signed(b)) <<< 1;
      sc = ro ? RS_W'($signed(c)) : '0;
      return sa + sb + sc;
   endfunction

   // whole pipe holds while a result waits
   assign en  = !rsp_valid_ff || !rsp_stall;
   assign pop = en && q_not_empty;

   // stage 1: per-row sums
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         rs_in[i] = row_sum(q_data.col_left[WIN_W-1-PIX_W*i -: PIX_W],
                            q_data.col_mid[WIN_W-1-PIX_W*i -: PIX_W],
                            q_data.col_right[WIN_W-1-PIX_W*i -: PIX_W],
                            q_data.left_on, q_data.right_on);
      end
   end

   // stage 2: row combine, sign split, reciprocal pick
   always_comb begin
      total = (s1_top_ff ? TOT_W'(s1_rs_ff[0]) : TOT_W'(0)) +
              (TOT_W'(s1_rs_ff[1]) <<< 1) +
              (s1_bot_ff ? TOT_W'(s1_rs_ff[2]) : TOT_W'(0));
      rf    = 3'd2 + 3'(s1_top_ff) + 3'(s1_bot_ff);
   end

   // output: scale back, restore sign, running check
   always_comb begin
      qmag      = s3_prod_ff[RECIP_SHIFT+Q_W-1:RECIP_SHIFT];
      qval      = s3_neg_ff ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
      check_sum = acc_ff + CHK_W'(qval);
      acc_in    = acc_ff;
      if (img_clear) begin
         acc_in = '0;
      end else if (en && s3_valid_ff) begin
         acc_in = s3_last_ff ? '0 : check_sum;
      end
   end

   // pipeline valids and check accumulator
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         acc_ff       <= '0;
      end else begin
         acc_ff <= acc_in;
         if (en) begin
            s1_valid_ff  <= pop;
            s2_valid_ff  <= s1_valid_ff;
            s3_valid_ff  <= s2_valid_ff;
            rsp_valid_ff <= s3_valid_ff;
         end
      end
   end

   // pipeline payload
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            s1_rs_ff[i] <= rs_in[i];
         end
         s1_top_ff  <= q_data.top_on;
         s1_bot_ff  <= q_data.bot_on;
         s1_cf_ff   <= 3'd2 + 3'(q_data.left_on) + 3'(q_data.right_on);
         s1_last_ff <= q_data.last;

         s2_neg_ff   <= total[TOT_W-1];
         s2_mag_ff   <= total[TOT_W-1] ? MAG_W'(-total) : MAG_W'(total);
         s2_recip_ff <= recip(rf, s1_cf_ff);
         s2_last_ff  <= s1_last_ff;

         s3_prod_ff <= PROD_W'(s2_mag_ff) * PROD_W'(s2_recip_ff);
         s3_neg_ff  <= s2_neg_ff;
         s3_last_ff <= s2_last_ff;

         rsp_data_ff.filtered_value <= qval[PIX_W-1:0];
         rsp_data_ff.running_check  <= check_sum;
         rsp_data_ff.last_of_image  <= s3_last_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> design/edge_normalized_smoothing_3x3.sv
// top level: 3x3 edge-normalized smoothing filter with line stores and running check
// A request holds req_stall high until the front end is idle again; a pixel request that
// yields two results also passes ST_PIX2, and a drain of the first column passes ST_DRN_A first.
// Results pass through the stages s1, s2, s3 and the result register. Synchronous active-high
// reset clears control state; sizes return to 1x1.
// Line stores are not cleared; no result depends on an entry before it is written.
module edge_normalized_smoothing_3x3 import ens3_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_item_type         req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_item_type         rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CNT_W-1:0]     csr_wdata
);

   logic          push;
   job_type       push_data;
   logic          pop;
   job_type       pop_data;
   logic          q_not_empty;
   logic [Q_AW:0] q_count;
   logic          img_clear;

   // request intake and line stores
   ens3_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .q_count   (q_count),
      .push      (push),
      .push_data (push_data),
      .img_clear (img_clear)
   );

   // job queue
   ens3_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .not_empty (q_not_empty),
      .count     (q_count)
   );

   // filter arithmetic and results
   ens3_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_data      (pop_data),
      .pop         (pop),
      .img_clear   (img_clear),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule

>>> design/ens3_checker.sv
// port-level checker for the smoothing filter and its bind to the top level
module ens3_checker import ens3_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input req_item_type         req_data,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input rsp_item_type         rsp_data,
   input logic                 csr_valid,
   input logic                 csr_ready,
   input logic [CSR_IDX_W-1:0] csr_index,
   input logic [CNT_W-1:0]     csr_wdata
);

   logic signed [CHK_W-1:0] exp_ff;
   logic                    rsp_take;
   logic                    csr_take;

   assign rsp_take = rsp_valid && !rsp_stall;
   assign csr_take = csr_valid && csr_ready &&
                     ((csr_index == CSR_IMAGE_ROWS) || (csr_index == CSR_IMAGE_COLS));

   // expected check base: restarts after the last pixel or a size write
   always_ff @(posedge clock) begin
      if (reset || csr_take) begin
         exp_ff <= '0;
      end else if (rsp_take) begin
         exp_ff <= rsp_data.last_of_image ? '0 : rsp_data.running_check;
      end
   end

   // no result right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // running check adds each filtered value to the previous check of the image
   a_check_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_take |-> rsp_data.running_check ==
                   exp_ff + CHK_W'(rsp_data.filtered_value))
      else $error("running check does not follow filtered values");

   // register writes are never refused
   a_no_req_when_csr: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("register write refused");

endmodule

bind edge_normalized_smoothing_3x3 ens3_checker u_checker (.*);
